[sv/dbwl_pkg.sv]
// shared constants, types and helper functions for the de bruijn window locator
package dbwl_pkg;

  localparam int unsigned MaxLength  = 1024;
  localparam int unsigned MaxWindow  = 10;
  localparam int unsigned NodeCnt    = 1 << (MaxWindow - 1);
  localparam int unsigned TableSize  = 1 << MaxWindow;
  localparam int unsigned StackDepth = TableSize + 1;

  localparam int unsigned LenW  = 11;
  localparam int unsigned WinW  = 10;
  localparam int unsigned VcW   = 4;
  localparam int unsigned KW    = 4;
  localparam int unsigned NodeW = $clog2(NodeCnt);
  localparam int unsigned PtrW  = $clog2(StackDepth);

  typedef struct packed {
    logic             go;
    logic [NodeW-1:0] nmask;
  } walk_ctrl_t;

  typedef struct packed {
    logic            done;
    logic [PtrW-1:0] cnt;
  } walk_stat_t;

  // clamp the written length into the supported range
  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] seq);
    logic [LenW-1:0] n;
    n = seq;
    if (n < LenW'(2)) n = LenW'(2);
    if (n > LenW'(MaxLength)) n = LenW'(MaxLength);
    return n;
  endfunction

  // least k with n - k + 1 <= 2^k
  function automatic logic [KW-1:0] win_len(input logic [LenW-1:0] n);
    logic [KW-1:0] k;
    logic [11:0]   t;
    k = KW'(MaxWindow);
    for (int i = MaxWindow; i >= 1; i--) begin
      t = {1'b0, n} + 12'd1 - 12'(i);
      if (t <= (12'd1 << i)) k = KW'(i);
    end
    return k;
  endfunction

endpackage

[sv/dbwl_walk.sv]
// euler circuit walk over the de bruijn graph: edge marks, node stack and circuit bits
module dbwl_walk import dbwl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  walk_ctrl_t       ctrl_i,
  output walk_stat_t       stat_o,
  input  logic [PtrW-1:0]  circ_raddr_i,
  output logic             circ_rdata_o
);

  typedef enum logic [2:0] {
    W_IDLE,
    W_CLR,
    W_RD,
    W_EV,
    W_POP
  } wstate_e;

  wstate_e          state_q, state_d;
  logic [NodeW-1:0] clr_q, clr_d;
  logic [NodeW-1:0] top_q, top_d;
  logic [PtrW-1:0]  sp_q, sp_d;
  logic [PtrW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;

  logic [1:0]       edge_mem [NodeCnt];
  logic [NodeW-1:0] stack_mem [StackDepth];
  logic             circ_mem [StackDepth];

  logic [1:0]       edge_rdata_q;
  logic [NodeW-1:0] stack_rdata_q;
  logic             circ_rdata_q;

  logic             edge_we;
  logic [NodeW-1:0] edge_waddr;
  logic [1:0]       edge_wdata;
  logic             stack_we;
  logic [PtrW-1:0]  stack_waddr;
  logic [NodeW-1:0] stack_wdata;
  logic             circ_we;

  logic             push0, push1;
  logic [NodeW-1:0] next_node;

  assign push0     = !edge_rdata_q[0];
  assign push1     = edge_rdata_q[0] && !edge_rdata_q[1];
  assign next_node = {top_q[NodeW-2:0], push1} & ctrl_i.nmask;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    top_d       = top_q;
    sp_d        = sp_q;
    cnt_d       = cnt_q;
    done_d      = 1'b0;
    edge_we     = 1'b0;
    edge_waddr  = clr_q;
    edge_wdata  = 2'b00;
    stack_we    = 1'b0;
    stack_waddr = sp_q;
    stack_wdata = next_node;
    circ_we     = 1'b0;
    case (state_q)
      W_IDLE: begin
        if (ctrl_i.go) begin
          clr_d   = '0;
          state_d = W_CLR;
        end
      end
      W_CLR: begin
        edge_we = 1'b1;
        clr_d   = clr_q + NodeW'(1);
        if (clr_q == ctrl_i.nmask) begin
          // seed the stack with node zero
          stack_we    = 1'b1;
          stack_waddr = '0;
          stack_wdata = '0;
          sp_d        = PtrW'(1);
          top_d       = '0;
          cnt_d       = '0;
          state_d     = W_RD;
        end
      end
      W_RD: begin
        state_d = W_EV;
      end
      W_EV: begin
        if (push0 || push1) begin
          edge_we    = 1'b1;
          edge_waddr = top_q;
          edge_wdata = edge_rdata_q | (push0 ? 2'b01 : 2'b10);
          stack_we   = 1'b1;
          sp_d       = sp_q + PtrW'(1);
          top_d      = next_node;
          state_d    = W_RD;
        end else begin
          circ_we = 1'b1;
          cnt_d   = cnt_q + PtrW'(1);
          sp_d    = sp_q - PtrW'(1);
          if (sp_q == PtrW'(1)) begin
            done_d  = 1'b1;
            state_d = W_IDLE;
          end else begin
            state_d = W_POP;
          end
        end
      end
      W_POP: begin
        // new stack top arrives from the read issued at the pop
        top_d   = stack_rdata_q;
        state_d = W_RD;
      end
      default: begin
        state_d = W_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_IDLE;
      clr_q   <= '0;
      top_q   <= '0;
      sp_q    <= '0;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      top_q   <= top_d;
      sp_q    <= sp_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    edge_rdata_q <= edge_mem[top_q];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    stack_rdata_q <= stack_mem[sp_q - PtrW'(2)];
  end

  always_ff @(posedge clk_i) begin
    if (circ_we) circ_mem[cnt_q] <= top_q[0];
    circ_rdata_q <= circ_mem[circ_raddr_i];
  end

  assign stat_o.done  = done_q;
  assign stat_o.cnt   = cnt_q;
  assign circ_rdata_o = circ_rdata_q;

endmodule

[sv/de_bruijn_window_locator.sv]
// top level: query control, table build sequencer and position table
// A query with valid_count_i below the window length k answers the
// clamped sequence length minus valid_count_i in the cycle after start,
// and busy stays low. A full window is looked up in the position table:
// the read is issued at start, the registered read data is taken in the
// lookup state and the result word is registered from it; busy is high
// in the lookup state. The first full-window query after seq_length
// changes first builds the table: a clearing pass over the 2^k entries
// of the position table, a clearing pass over the 2^(k-1) edge marks,
// the euler walk, then a pass filling the table, with busy high
// throughout. For length 2 the walk is skipped. The result strobe lasts
// one cycle and cannot be held off.
module de_bruijn_window_locator import dbwl_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             seq_length_we_i,
  input  logic [LenW-1:0]  seq_length_i,
  input  logic             start,
  output logic             busy,
  input  logic [WinW-1:0]  window_bits_i,
  input  logic [VcW-1:0]   valid_count_i,
  output logic             strobe_o,
  output logic [LenW-1:0]  position_o
);

  typedef enum logic [2:0] {
    T_IDLE,
    T_CLR,
    T_WALK,
    T_FPRE,
    T_FILL,
    T_QRD,
    T_LOOK
  } tstate_e;

  tstate_e          state_q, state_d;
  logic [LenW-1:0]  seq_q, seq_d;
  logic             ready_q, ready_d;
  logic [WinW-1:0]  win_q, win_d;
  logic [WinW-1:0]  ctr_q, ctr_d;
  logic [WinW-1:0]  curr_q, curr_d;
  logic [LenW-1:0]  pos_q, pos_d;
  logic             strobe_q, strobe_d;

  logic [LenW-1:0]  n;
  logic [KW-1:0]    k;
  logic [WinW-1:0]  kmask;
  logic [NodeW-1:0] nmask;
  logic             n2;
  logic [LenW-1:0]  km1;

  logic [WinW-1:0]  pos_mem [TableSize];
  logic [WinW-1:0]  pos_rdata_q;
  logic             pos_we;
  logic [WinW-1:0]  pos_waddr;
  logic [WinW-1:0]  pos_wdata;
  logic [WinW-1:0]  pos_raddr;

  walk_ctrl_t       walk_ctrl;
  walk_stat_t       walk_stat;
  logic [LenW-1:0]  circ_j;
  logic [PtrW-1:0]  circ_raddr;
  logic             circ_rdata;
  logic             fill_bit;
  logic             lead_done;

  assign n     = eff_len(seq_q);
  assign k     = win_len(n);
  assign kmask = WinW'((11'd1 << k) - 11'd1);
  assign nmask = NodeW'((10'd1 << (k - KW'(1))) - 10'd1);
  assign n2    = (n == LenW'(2));
  assign km1   = LenW'(k) - LenW'(1);

  // label j (j >= k-1) sits in the circuit at cnt + k - 3 - j
  assign circ_j     = (state_q == T_FPRE) ? '0 : ({1'b0, ctr_q} + LenW'(1));
  assign circ_raddr = (circ_j >= km1) ?
                      PtrW'(walk_stat.cnt + PtrW'(k) - PtrW'(3) - circ_j) : '0;

  assign lead_done = ({1'b0, ctr_q} >= km1);
  assign fill_bit  = n2 ? ctr_q[0] : (lead_done ? circ_rdata : 1'b0);

  assign walk_ctrl.go    = (state_q == T_CLR) && (ctr_q == kmask) && !n2;
  assign walk_ctrl.nmask = nmask;

  dbwl_walk u_walk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (walk_ctrl),
    .stat_o       (walk_stat),
    .circ_raddr_i (circ_raddr),
    .circ_rdata_o (circ_rdata)
  );

  always_comb begin
    state_d   = state_q;
    seq_d     = seq_q;
    ready_d   = ready_q;
    win_d     = win_q;
    ctr_d     = ctr_q;
    curr_d    = curr_q;
    pos_d     = pos_q;
    strobe_d  = 1'b0;
    pos_we    = 1'b0;
    pos_waddr = ctr_q;
    pos_wdata = '0;
    pos_raddr = win_q & kmask;
    if (seq_length_we_i) begin
      seq_d = seq_length_i;
      if (seq_length_i != seq_q) ready_d = 1'b0;
    end
    case (state_q)
      T_IDLE: begin
        pos_raddr = window_bits_i & kmask;
        if (start) begin
          win_d = window_bits_i;
          if (valid_count_i < k) begin
            pos_d    = n - LenW'(valid_count_i);
            strobe_d = 1'b1;
          end else if (ready_q) begin
            state_d = T_LOOK;
          end else begin
            ctr_d   = '0;
            state_d = T_CLR;
          end
        end
      end
      T_CLR: begin
        pos_we = 1'b1;
        ctr_d  = ctr_q + WinW'(1);
        if (ctr_q == kmask) state_d = n2 ? T_FPRE : T_WALK;
      end
      T_WALK: begin
        if (walk_stat.done) state_d = T_FPRE;
      end
      T_FPRE: begin
        ctr_d   = '0;
        curr_d  = '0;
        state_d = T_FILL;
      end
      T_FILL: begin
        curr_d    = {curr_q[WinW-2:0], fill_bit} & kmask;
        pos_we    = lead_done;
        pos_waddr = curr_d;
        pos_wdata = WinW'({1'b0, ctr_q} - km1);
        ctr_d     = ctr_q + WinW'(1);
        if ({1'b0, ctr_q} == n - LenW'(1)) begin
          ready_d = 1'b1;
          state_d = T_QRD;
        end
      end
      T_QRD: begin
        state_d = T_LOOK;
      end
      T_LOOK: begin
        pos_d    = {1'b0, pos_rdata_q};
        strobe_d = 1'b1;
        state_d  = T_IDLE;
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_IDLE;
      seq_q    <= LenW'(2);
      ready_q  <= 1'b0;
      win_q    <= '0;
      ctr_q    <= '0;
      curr_q   <= '0;
      pos_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      seq_q    <= seq_d;
      ready_q  <= ready_d;
      win_q    <= win_d;
      ctr_q    <= ctr_d;
      curr_q   <= curr_d;
      pos_q    <= pos_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pos_we) pos_mem[pos_waddr] <= pos_wdata;
    pos_rdata_q <= pos_mem[pos_raddr];
  end

  assign busy       = (state_q != T_IDLE);
  assign strobe_o   = strobe_q;
  assign position_o = pos_q;

endmodule

[bench/tb.sv]
// self-checking testbench for the de bruijn window locator
`timescale 1ns / 100ps

module tb;
  import dbwl_pkg::*;

  localparam int unsigned PhaseCnt    = 14;
  localparam int unsigned RandPerSet  = 110;
  localparam int unsigned DirectedSet = 5;
  localparam int unsigned StallLimit  = 40000;
  localparam int unsigned LongCount   = 15;

  typedef struct packed {
    logic [WinW-1:0] bits;
    logic [VcW-1:0]  cnt;
  } query_t;

  logic            clk_i;
  logic            rst_ni;
  logic            seq_length_we_i;
  logic [LenW-1:0] seq_length_i;
  logic            start;
  logic            busy;
  logic [WinW-1:0] window_bits_i;
  logic [VcW-1:0]  valid_count_i;
  logic            strobe_o;
  logic [LenW-1:0] position_o;

  query_t          query_backlog[$];
  logic [LenW-1:0] pending_positions[$];
  logic            took_word;
  int unsigned     gap_pct;
  int unsigned     errors;
  int unsigned     stall_cycles;

  // shadow of the block's length register and its position map
  logic [LenW-1:0] len_reg;
  logic            map_valid;
  logic [9:0]      pos_map[TableSize];

  de_bruijn_window_locator u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .seq_length_we_i (seq_length_we_i),
    .seq_length_i    (seq_length_i),
    .start           (start),
    .busy            (busy),
    .window_bits_i   (window_bits_i),
    .valid_count_i   (valid_count_i),
    .strobe_o        (strobe_o),
    .position_o      (position_o)
  );

  function automatic int unsigned clamp_len(input logic [LenW-1:0] v);
    int unsigned n;
    n = 32'(v);
    if (n < 2) n = 2;
    if (n > MaxLength) n = MaxLength;
    return n;
  endfunction

  function automatic int unsigned window_size(input int unsigned n);
    int unsigned k;
    k = 1;
    while (k < 31 && n - k + 1 > (1 << k)) k++;
    return k;
  endfunction

  // euler walk over the order k-1 graph, then index every k-bit window
  function automatic void build_label_map(input int unsigned n, input int unsigned k);
    bit [1:0]    marks[NodeCnt];
    int unsigned walk[StackDepth];
    bit          circ[StackDepth];
    bit          lab[MaxLength];
    int unsigned sp, cnt, cur, nod, nmask, kmask, j;
    kmask = (1 << k) - 1;
    cnt = 0;
    foreach (marks[i]) marks[i] = '0;
    foreach (pos_map[i]) pos_map[i] = '0;
    if (n == 2) begin
      lab[0] = 1'b0;
      lab[1] = 1'b1;
    end else begin
      nmask = (1 << (k - 1)) - 1;
      walk[0] = 0;
      sp = 1;
      while (sp > 0) begin
        nod = walk[sp - 1] & nmask;
        if (!marks[nod][0]) begin
          marks[nod][0] = 1'b1;
          if (sp < StackDepth) begin
            walk[sp] = (nod << 1) & nmask;
            sp++;
          end
        end else if (!marks[nod][1]) begin
          marks[nod][1] = 1'b1;
          if (sp < StackDepth) begin
            walk[sp] = ((nod << 1) | 1) & nmask;
            sp++;
          end
        end else begin
          if (cnt < StackDepth) begin
            circ[cnt] = nod[0];
            cnt++;
          end
          sp--;
        end
      end
      // k-1 leading zeros, then the circuit read backwards
      for (int unsigned i = 0; i < n; i++) begin
        lab[i] = 1'b0;
        if (i + 1 >= k) begin
          j = i + 2 - k;
          if (j < cnt) lab[i] = circ[cnt - 1 - j];
        end
      end
    end
    cur = 0;
    for (int unsigned i = 0; i < k && i < n; i++) cur = ((cur << 1) | lab[i]) & kmask;
    for (int unsigned i = 0; i + k <= n; i++) begin
      pos_map[cur & (TableSize - 1)] = i[9:0];
      if (i + k < n) cur = ((cur << 1) | lab[i + k]) & kmask;
    end
    map_valid = 1'b1;
  endfunction

  function automatic logic [LenW-1:0] locate_window(input logic [WinW-1:0] bits,
                                                    input logic [VcW-1:0] cnt);
    int unsigned n, k;
    n = clamp_len(len_reg);
    k = window_size(n);
    if (cnt < k) return LenW'(n - cnt);
    if (!map_valid) build_label_map(n, k);
    return LenW'(pos_map[bits & ((1 << k) - 1)]);
  endfunction

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (query_backlog.size() != 0 || pending_positions.size() != 0 || start || busy);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // driver: a word stays on the ports until it is taken
  always @(negedge clk_i) begin : driver
    query_t q;
    if (rst_ni && (!start || took_word)) begin
      if (query_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
        q = query_backlog.pop_front();
        start         <= 1'b1;
        window_bits_i <= q.bits;
        valid_count_i <= q.cnt;
      end else begin
        start         <= 1'b0;
        window_bits_i <= WinW'($urandom);
        valid_count_i <= VcW'($urandom);
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin : scoreboard
    logic [LenW-1:0] want;
    if (rst_ni) begin
      took_word <= start && !busy;
      if (start && !busy) begin
        pending_positions = {pending_positions, locate_window(window_bits_i, valid_count_i)};
      end
      if (strobe_o) begin
        if (pending_positions.size() == 0) begin
          $error("position: unexpected word %0d", position_o);
          errors++;
        end else begin
          want = pending_positions.pop_front();
          if (position_o !== want) begin
            $error("position: expected %0d, actual %0d", want, position_o);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if (!rst_ni || (start && !busy) || strobe_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("de_bruijn_window_locator regression: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : sequencer
    logic [LenW-1:0] len_plan[PhaseCnt];
    query_t          q;
    int unsigned     n, k, r;
    rst_ni          = 1'b0;
    start           = 1'b0;
    took_word       = 1'b0;
    seq_length_we_i = 1'b0;
    seq_length_i    = '0;
    window_bits_i   = '0;
    valid_count_i   = '0;
    gap_pct         = 24;
    errors          = 0;
    stall_cycles    = 0;
    len_reg         = LenW'(2);
    map_valid       = 1'b0;
    // extremes, out-of-range values and same-value rewrites first
    len_plan = '{LenW'(2), LenW'(2), LenW'(1024), LenW'(3), LenW'(0), LenW'(1),
                 LenW'(2047), LenW'(2047), LenW'(4), LenW'(17), LenW'(1025), LenW'(5),
                 LenW'($urandom_range(40, 2)), LenW'($urandom_range(2047, 0))};
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    for (int p = 0; p < PhaseCnt; p++) begin
      gap_pct = (p < 5) ? 24 : ((p < 10) ? 69 : 0);
      wait_idle();
      @(negedge clk_i);
      seq_length_we_i <= 1'b1;
      seq_length_i    <= len_plan[p];
      @(negedge clk_i);
      seq_length_we_i <= 1'b0;
      seq_length_i    <= LenW'($urandom);
      if (len_plan[p] != len_reg) begin
        len_reg   = len_plan[p];
        map_valid = 1'b0;
      end
      n = clamp_len(len_reg);
      k = window_size(n);
      if (p < DirectedSet) begin
        query_backlog = {query_backlog, query_t'{bits: '0, cnt: VcW'(0)}};
        query_backlog = {query_backlog, query_t'{bits: '1, cnt: VcW'(k - 1)}};
        query_backlog = {query_backlog, query_t'{bits: '0, cnt: VcW'(k)}};
        query_backlog = {query_backlog, query_t'{bits: '1, cnt: VcW'(k)}};
        query_backlog = {query_backlog, query_t'{bits: '1, cnt: VcW'(LongCount)}};
      end
      repeat (RandPerSet) begin
        r = $urandom_range(99);
        q.bits = WinW'($urandom);
        if (r < 25) q.cnt = VcW'($urandom_range(k - 1, 0));
        else if (r < 35) q.cnt = VcW'($urandom_range(LongCount, k + 1));
        else q.cnt = VcW'(k);
        query_backlog = {query_backlog, q};
      end
    end
    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("de_bruijn_window_locator regression: pass");
    end else begin
      $display("de_bruijn_window_locator regression: fail");
    end
    $finish;
  end

endmodule

[de_bruijn_window_locator.f]
sv/dbwl_pkg.sv
sv/dbwl_walk.sv
sv/de_bruijn_window_locator.sv
bench/tb.sv
